// File: src/polyphase_rational_resampler_top_assert.svh
// Assertion macros used by the resampler's checker, prr_checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef POLYPHASE_RATIONAL_RESAMPLER_TOP_ASSERT_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/prr_pkg.sv
// Package of the polyphase resampler: fixed widths, codes and shared types.
// Used by prr_cell, the top level and the checker; depends on nothing.
package prr_pkg;

  localparam int TAP_W      = 16;   // Q1.15 coefficient width
  localparam int TAP_FRAC   = 15;   // fraction bits of a coefficient
  localparam int TAP_DEPTH  = 256;  // prototype tap store entries
  localparam int TAP_AW     = 8;    // tap store address width
  localparam int IF_W       = 5;    // interpolation register width
  localparam int DF_W       = 8;    // decimation register width
  localparam int TPP_W      = 5;    // taps-per-phase register width
  localparam int PHASE_W    = 5;    // branch number carried by a token
  localparam int PCNT_W     = 9;    // phase counter width
  localparam int OUT_PH_W   = 4;    // branch number reported on the output
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TAP    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP = 2'd0,
    CFG_DECIM  = 2'd1,
    CFG_TAPS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  // One output computation travelling down the cell chain.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [PHASE_W-1:0] phase;
  } tok_t;

endpackage

// File: src/prr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/prr_cell.sv
// One tap cell of the resampler chain: a delay-line entry, a private copy
// of the tap store and a multiply-accumulate stage. Depends on prr_pkg, prr_ram.
module prr_cell #(
  parameter int INDEX        = 0,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_W        = 37
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               shift_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_i,
  output logic signed [SAMPLE_WIDTH-1:0]     sample_o,
  input  prr_pkg::tok_t                      tok_i,
  input  logic signed [ACC_W-1:0]            psum_i,
  input  logic                               use_i,
  input  logic [prr_pkg::IF_W-1:0]           interp_i,
  input  logic                               tap_we_i,
  input  logic [prr_pkg::TAP_AW-1:0]         tap_waddr_i,
  input  logic [prr_pkg::TAP_W-1:0]          tap_wdata_i,
  output prr_pkg::tok_t                      tok_o,
  output logic signed [ACC_W-1:0]            psum_o,
  output logic                               busy_o
);

  // Position width covers INDEX * interp + phase with interp and phase below 32.
  localparam int PosW = ($clog2(INDEX + 1) + 6 > 9) ? $clog2(INDEX + 1) + 6 : 9;

  logic signed [SAMPLE_WIDTH-1:0]              sample_q;
  prr_pkg::tok_t                               tok_a_q, tok_b_q;
  logic signed [ACC_W-1:0]                     psum_a_q, psum_b_q;
  logic                                        use_a_q;
  logic [PosW-1:0]                             pos;
  logic                                        in_range;
  logic signed [prr_pkg::TAP_W-1:0]            tap_rd;
  logic signed [prr_pkg::TAP_W+SAMPLE_WIDTH-1:0] prod;

  assign pos      = PosW'(INDEX) * PosW'(interp_i) + PosW'(tok_i.phase);
  assign in_range = pos < PosW'(prr_pkg::TAP_DEPTH);

  prr_ram #(
    .WIDTH (prr_pkg::TAP_W),
    .DEPTH (prr_pkg::TAP_DEPTH)
  ) u_taps (
    .clk_i   (clk_i),
    .we_i    (tap_we_i),
    .waddr_i (tap_waddr_i),
    .wdata_i (tap_wdata_i),
    .re_i    (adv_i),
    .raddr_i (pos[prr_pkg::TAP_AW-1:0]),
    .rdata_o (tap_rd)
  );

  assign prod = tap_rd * sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      tok_a_q  <= '0;
      tok_b_q  <= '0;
    end else begin
      if (shift_i) begin
        sample_q <= sample_i;
      end
      if (adv_i) begin
        tok_a_q <= tok_i;
        tok_b_q <= tok_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      psum_a_q <= psum_i;
      use_a_q  <= use_i && in_range;
      psum_b_q <= psum_a_q + (use_a_q ? ACC_W'(prod) : '0);
    end
  end

  assign sample_o = sample_q;
  assign tok_o    = tok_b_q;
  assign psum_o   = psum_b_q;
  assign busy_o   = tok_a_q.valid || tok_b_q.valid;

endmodule

// File: src/polyphase_rational_resampler_top.sv
// Polyphase rational resampler, top level: control, output register, cell chain.
// Depends on prr_pkg, prr_cell and prr_ram.
//
// The block resamples a stream by interp_factor / decim_factor with a
// polyphase FIR. An input beat either writes one prototype tap (kind = 1)
// or delivers one sample (kind = 0). Prototype tap p belongs to branch
// p mod interp_factor at position p div interp_factor. A sample shifts into
// the delay line, and the block then produces one output beat per branch
// visited while the phase counter stays below interp_factor, at most
// MAX_INTERP beats; the last of them carries last = 1. Outputs are the Q1.15
// dot product rounded half up and saturated to SAMPLE_WIDTH bits.
// The filter is a chain of MAX_TAPS_PER_PHASE cells. Cell k holds delay-line
// entry k and its own copy of the 256-entry tap store, so every cell reads
// its tap in the same cycle and a partial sum passes two registers in each cell.
// A tap write leaves the block idle, ready for the next input beat. While the
// output is not stalled, the control issues one output per cycle into the
// chain, and the next input waits until the chain has drained; output
// back-pressure stalls the whole chain. The last result may still wait in
// the output register while the next input beat is taken.
// After reset the block clears all 256 entries of each tap store to zero
// and takes no input beat during that time; configuration writes are
// always taken. Configuration must only change while the block is idle.
module polyphase_rational_resampler_top #(
  parameter int MAX_INTERP         = 16,
  parameter int MAX_TAPS_PER_PHASE = 16,
  parameter int SAMPLE_WIDTH       = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [prr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  logic [prr_pkg::TAP_AW-1:0]        tap_index_i,
  input  logic signed [prr_pkg::TAP_W-1:0]  tap_value_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  output logic [prr_pkg::OUT_PH_W-1:0]      phase_used_o,
  output logic                              last_o
);

  localparam int AccW = prr_pkg::TAP_W + SAMPLE_WIDTH + $clog2(MAX_TAPS_PER_PHASE) + 1;
  localparam int CntW = $clog2(MAX_INTERP + 1);
  localparam int NCell = MAX_TAPS_PER_PHASE;

  localparam logic signed [AccW-1:0] RoundK = AccW'(32'sd1 <<< (prr_pkg::TAP_FRAC - 1));
  localparam logic signed [AccW-1:0] SatHi =
    {{(AccW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo =
    {{(AccW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // Control state.
  prr_pkg::state_e                state_q, state_d;
  logic [prr_pkg::PCNT_W-1:0]     phase_q, phase_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [prr_pkg::TAP_AW-1:0]     clr_q, clr_d;

  // Configuration registers, raw as written.
  logic [prr_pkg::IF_W-1:0]       interp_r_q;
  logic [prr_pkg::DF_W-1:0]       decim_r_q;
  logic [prr_pkg::TPP_W-1:0]      taps_r_q;

  // Effective register values after clamping.
  logic [prr_pkg::IF_W-1:0]       interp;
  logic [prr_pkg::DF_W-1:0]       decim;
  logic [prr_pkg::TPP_W-1:0]      ntaps;
  logic [prr_pkg::PCNT_W-1:0]     interp_ext;
  logic [prr_pkg::PCNT_W-1:0]     phase_nxt;

  // Output register.
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic [prr_pkg::OUT_PH_W-1:0]   out_phase_q;
  logic                           out_last_q;

  // Chain wiring.
  prr_pkg::tok_t                  tok    [NCell+1];
  logic signed [AccW-1:0]         psum   [NCell+1];
  logic signed [SAMPLE_WIDTH-1:0] samp   [NCell+1];
  logic [NCell-1:0]               busy;
  logic [NCell-1:0]               cell_use;
  logic                           chain_busy;

  logic                           adv;
  logic                           emit;
  logic                           inject;
  logic                           inj_last;
  logic                           shift;
  logic                           tap_we;
  logic [prr_pkg::TAP_AW-1:0]     tap_waddr;
  logic [prr_pkg::TAP_W-1:0]      tap_wdata;

  logic signed [AccW-1:0]         rnd;
  logic signed [AccW-1:0]         quo;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  // A zero register acts as 1; values above the built size are capped.
  always_comb begin
    if (interp_r_q == '0) begin
      interp = prr_pkg::IF_W'(1);
    end else if (int'(interp_r_q) > MAX_INTERP) begin
      interp = prr_pkg::IF_W'(MAX_INTERP);
    end else begin
      interp = interp_r_q;
    end
    decim = (decim_r_q == '0) ? prr_pkg::DF_W'(1) : decim_r_q;
    if (taps_r_q == '0) begin
      ntaps = prr_pkg::TPP_W'(1);
    end else if (int'(taps_r_q) > MAX_TAPS_PER_PHASE) begin
      ntaps = prr_pkg::TPP_W'(MAX_TAPS_PER_PHASE);
    end else begin
      ntaps = taps_r_q;
    end
  end

  assign interp_ext = prr_pkg::PCNT_W'(interp);
  assign phase_nxt  = phase_q + prr_pkg::PCNT_W'(decim);
  assign emit       = (phase_q < interp_ext) && (cnt_q < CntW'(MAX_INTERP));

  // The whole chain and the output register move together unless a result
  // sits in the output register and the consumer is not taking it.
  assign adv        = !out_valid_q || out_ready_i;
  assign chain_busy = |busy;

  // Configuration port: always ready, writes beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_r_q <= prr_pkg::IF_W'(1);
      decim_r_q  <= prr_pkg::DF_W'(1);
      taps_r_q   <= prr_pkg::TPP_W'(1);
    end else if (cfg_valid_i) begin
      case (prr_pkg::cfg_idx_e'(cfg_index_i))
        prr_pkg::CFG_INTERP: begin
          interp_r_q <= cfg_data_i[prr_pkg::IF_W-1:0];
        end
        prr_pkg::CFG_DECIM: begin
          decim_r_q <= cfg_data_i[prr_pkg::DF_W-1:0];
        end
        prr_pkg::CFG_TAPS: begin
          taps_r_q <= cfg_data_i[prr_pkg::TPP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: clears the tap stores after reset, takes input beats while
  // idle, issues one output token per cycle into the chain while the output
  // is not stalled, then waits for the chain to empty.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    inject     = 1'b0;
    inj_last   = 1'b0;
    tap_we     = 1'b0;
    tap_waddr  = tap_index_i;
    tap_wdata  = tap_value_i;
    case (state_q)
      prr_pkg::ST_CLEAR: begin
        tap_we    = 1'b1;
        tap_waddr = clr_q;
        tap_wdata = '0;
        clr_d     = clr_q + prr_pkg::TAP_AW'(1);
        if (clr_q == prr_pkg::TAP_AW'(prr_pkg::TAP_DEPTH - 1)) begin
          state_d = prr_pkg::ST_IDLE;
        end
      end
      prr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == prr_pkg::KIND_TAP) begin
            tap_we = 1'b1;
          end else begin
            cnt_d   = '0;
            state_d = prr_pkg::ST_ISSUE;
          end
        end
      end
      prr_pkg::ST_ISSUE: begin
        if (emit) begin
          if (adv) begin
            inject   = 1'b1;
            inj_last = (phase_nxt >= interp_ext) || (cnt_q == CntW'(MAX_INTERP - 1));
            phase_d  = phase_nxt;
            cnt_d    = cnt_q + CntW'(1);
          end
        end else begin
          // End of this sample's outputs: step back by one input period, or to zero.
          phase_d = (phase_q >= interp_ext) ? phase_q - interp_ext : '0;
          state_d = prr_pkg::ST_DRAIN;
        end
      end
      prr_pkg::ST_DRAIN: begin
        if (!chain_busy) begin
          state_d = prr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prr_pkg::ST_CLEAR;
      phase_q <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  assign shift = in_valid_i && in_ready_o && (kind_i == prr_pkg::KIND_SAMPLE);

  // Head of the chain.
  assign tok[0].valid = inject;
  assign tok[0].last  = inj_last;
  assign tok[0].phase = phase_q[prr_pkg::PHASE_W-1:0];
  assign psum[0]      = '0;
  assign samp[0]      = sample_in_i;

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    assign cell_use[g] = (g < int'(ntaps));

    prr_cell #(
      .INDEX        (g),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_W        (AccW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .shift_i     (shift),
      .sample_i    (samp[g]),
      .sample_o    (samp[g+1]),
      .tok_i       (tok[g]),
      .psum_i      (psum[g]),
      .use_i       (cell_use[g]),
      .interp_i    (interp),
      .tap_we_i    (tap_we),
      .tap_waddr_i (tap_waddr),
      .tap_wdata_i (tap_wdata),
      .tok_o       (tok[g+1]),
      .psum_o      (psum[g+1]),
      .busy_o      (busy[g])
    );
  end

  // Round half up, drop the fraction bits, then saturate.
  always_comb begin
    rnd = psum[NCell] + RoundK;
    quo = rnd >>> prr_pkg::TAP_FRAC;
    if (quo > SatHi) begin
      sat = SatHi[SAMPLE_WIDTH-1:0];
    end else if (quo < SatLo) begin
      sat = SatLo[SAMPLE_WIDTH-1:0];
    end else begin
      sat = quo[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok[NCell].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tok[NCell].valid) begin
      out_sample_q <= sat;
      out_phase_q  <= tok[NCell].phase[prr_pkg::OUT_PH_W-1:0];
      out_last_q   <= tok[NCell].last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign phase_used_o = out_phase_q;
  assign last_o       = out_last_q;

endmodule

// File: src/prr_checker.sv
// Port-level checker for the resampler, bound to the top level below.
// Depends on prr_pkg and polyphase_rational_resampler_top_assert.svh.
`include "polyphase_rational_resampler_top_assert.svh"

module prr_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             kind_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [SAMPLE_WIDTH-1:0]          sample_out_o,
  input logic [prr_pkg::OUT_PH_W-1:0]     phase_used_o,
  input logic                             last_o
);

  // A stalled result beat must stay put.
  `PRR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(sample_out_o) && $stable(phase_used_o) && $stable(last_o),
    "output beat changed while stalled")

  // A tap write never causes a result.
  `PRR_ASSERT_NEXT(a_tap_silent, in_valid_i && in_ready_o && (kind_i == prr_pkg::KIND_TAP),
    !$rose(out_valid_o), "tap write produced a result beat")

  // A sample beat starts a computation, so no further input is taken at once.
  `PRR_ASSERT_NEXT(a_sample_busy,
    in_valid_i && in_ready_o && (kind_i == prr_pkg::KIND_SAMPLE),
    !in_ready_o, "input taken while a sample is being processed")

  // New results only appear while a sample is still in the filter.
  `PRR_ASSERT_NOW(a_result_while_busy, $rose(out_valid_o), !in_ready_o,
    "result appeared while the block was idle")

endmodule

bind polyphase_rational_resampler_top prr_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_prr_checker (.*);
